// ===== rtl/hacd_pkg.sv =====
// Package for the hex-ASCII CAN frame deframer.
// Holds sizes, command and result codes, the queue entry type and hex decoding.
// No dependencies.
package hacd_pkg;

   localparam int MAX_DATA_BYTES = 8;
   localparam int HEADER_BYTES   = 5;
   localparam int STORE_DEPTH    = HEADER_BYTES + MAX_DATA_BYTES;
   localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W          = $clog2(STORE_DEPTH);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_UPPER_B = 8'h42;
   localparam logic [7:0] CHAR_UPPER_C = 8'h43;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Y = 8'h59;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] HEX_TEN      = 8'd10;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FRAME    = 2'd0;
   localparam kind_type KIND_SIZE_ERR = 2'd1;
   localparam kind_type KIND_UNKNOWN  = 2'd2;
   localparam kind_type KIND_REBOOT   = 2'd3;

   typedef logic [2:0] op_code_type;
   localparam op_code_type OP_BYTE    = 3'd0;
   localparam op_code_type OP_CLEAR   = 3'd1;
   localparam op_code_type OP_CLOSE   = 3'd2;
   localparam op_code_type OP_UNKNOWN = 3'd3;
   localparam op_code_type OP_REBOOT  = 3'd4;

   typedef struct packed {
      op_code_type op;
      logic [7:0]  value;
   } queue_entry_type;

   function automatic logic [7:0] hex_value(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return c - CHAR_ZERO;
      end
      return c - CHAR_LOWER_A + HEX_TEN;
   endfunction

endpackage

// ===== rtl/hex_ascii_can_frame_deframer.sv =====
// Top level of the hex-ASCII CAN frame deframer.
// Instantiates hacd_front, hacd_queue and hacd_back; depends on hacd_pkg.
//
// Usage:
//   req channel: one received character per transfer on req_char_in.
//   rsp channel: at most one result per character: a frame, a size error,
//   an unknown command or a reboot report, selected by rsp_kind. Fields that
//   do not belong to the reported kind read as zero.
// Path: the character's transfer writes the queue, and the result register is
//   loaded from the queue when the receiver does not stall.
// Throughput: one character per clock while the queue is not full; every
//   stage takes one item per cycle unless the stage after it holds.
// Reset: synchronous, active high; clears the pending nibble, the reboot
//   expectation, the byte count, the overflow mark, the queue and the
//   result valid. Byte store contents are not cleared.
// Stall: while a result waits, the result register holds it; the two-entry
//   queue absorbs further operations and req_ready drops once it is full.
module hex_ascii_can_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_frame_id,
   output logic [3:0]  rsp_frame_size,
   output logic [63:0] rsp_frame_data,
   output logic [7:0]  rsp_reboot_flag,
   output logic [7:0]  rsp_bad_command
);
   import hacd_pkg::*;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_entry;

   hacd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .push_ready  (push_ready)
   );

   hacd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   hacd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop_ready       (pop_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_frame_size  (rsp_frame_size),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_reboot_flag (rsp_reboot_flag),
      .rsp_bad_command (rsp_bad_command)
   );

endmodule

// ===== rtl/hacd_front.sv =====
// Front end: accepts characters, pairs hex nibbles and classifies commands.
// Pushes operations into the queue. Depends on hacd_pkg.
module hacd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_char_in,
   output logic                     push_valid,
   output hacd_pkg::queue_entry_type push_entry,
   input  logic                     push_ready
);
   import hacd_pkg::*;

   logic       nibble_pending_ff, nibble_pending_in;
   logic [7:0] pending_char_ff, pending_char_in;
   logic       expect_reboot_ff, expect_reboot_in;
   logic       accept;
   logic [7:0] high_value;
   logic [7:0] low_value;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign high_value = hex_value(pending_char_ff);
   assign low_value  = hex_value(req_char_in);

   always_comb begin
      nibble_pending_in = nibble_pending_ff;
      pending_char_in   = pending_char_ff;
      expect_reboot_in  = expect_reboot_ff;
      push_valid        = 1'b0;
      push_entry.op     = OP_BYTE;
      push_entry.value  = req_char_in;
      if (accept) begin
         if (expect_reboot_ff) begin
            expect_reboot_in = 1'b0;
            push_valid       = 1'b1;
            push_entry.op    = OP_REBOOT;
         end else if (req_char_in >= CHAR_UPPER_A && req_char_in <= CHAR_UPPER_Z) begin
            if (req_char_in == CHAR_UPPER_B || req_char_in == CHAR_UPPER_C) begin
               push_valid    = 1'b1;
               push_entry.op = OP_CLEAR;
            end else if (req_char_in == CHAR_UPPER_Y) begin
               expect_reboot_in = 1'b1;
            end else if (req_char_in == CHAR_UPPER_F) begin
               push_valid    = 1'b1;
               push_entry.op = OP_CLOSE;
            end else begin
               push_valid    = 1'b1;
               push_entry.op = OP_UNKNOWN;
            end
         end else if (!nibble_pending_ff) begin
            pending_char_in   = req_char_in;
            nibble_pending_in = 1'b1;
         end else begin
            nibble_pending_in = 1'b0;
            push_valid        = 1'b1;
            push_entry.op     = OP_BYTE;
            push_entry.value  = {high_value[3:0], 4'b0000} | low_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_pending_ff <= 1'b0;
         pending_char_ff   <= 8'd0;
         expect_reboot_ff  <= 1'b0;
      end else begin
         nibble_pending_ff <= nibble_pending_in;
         pending_char_ff   <= pending_char_in;
         expect_reboot_ff  <= expect_reboot_in;
      end
   end

endmodule

// ===== rtl/hacd_queue.sv =====
// Short operation queue between front and back end.
// Register-based FIFO of queue entries. Depends on hacd_pkg.
module hacd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  hacd_pkg::queue_entry_type push_entry,
   output logic                      push_ready,
   output logic                      pop_valid,
   output hacd_pkg::queue_entry_type pop_entry,
   input  logic                      pop_ready
);
   import hacd_pkg::*;

   queue_entry_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = fill_ff != QFILL_W'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/hacd_back.sv =====
// Back end: byte store, count and overflow mark; closes frames and drives results.
// Owns the result register. Depends on hacd_pkg.
module hacd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   input  hacd_pkg::queue_entry_type pop_entry,
   output logic                      pop_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [31:0]               rsp_frame_id,
   output logic [3:0]                rsp_frame_size,
   output logic [63:0]               rsp_frame_data,
   output logic [7:0]                rsp_reboot_flag,
   output logic [7:0]                rsp_bad_command
);
   import hacd_pkg::*;

   logic [7:0]        store_ff [STORE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   logic [31:0]       frame_id_ff, frame_id_in;
   logic [3:0]        frame_size_ff, frame_size_in;
   logic [63:0]       frame_data_ff, frame_data_in;
   logic [7:0]        reboot_flag_ff, reboot_flag_in;
   logic [7:0]        bad_command_ff, bad_command_in;
   logic              do_pop;
   logic              store_write;
   logic              close_error;
   logic [7:0]        announced;
   logic [63:0]       data_bytes;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign announced = store_ff[4];

   assign close_error = overflow_ff
                     || count_ff < CNT_W'(HEADER_BYTES)
                     || announced != (8'(count_ff) - 8'(HEADER_BYTES))
                     || announced > 8'(MAX_DATA_BYTES);

   always_comb begin
      data_bytes = '0;
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
         if (8'(i) < announced) begin
            data_bytes[8*i +: 8] = store_ff[HEADER_BYTES + i];
         end
      end
   end

   always_comb begin
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      store_write    = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      kind_in        = kind_ff;
      frame_id_in    = frame_id_ff;
      frame_size_in  = frame_size_ff;
      frame_data_in  = frame_data_ff;
      reboot_flag_in = reboot_flag_ff;
      bad_command_in = bad_command_ff;
      if (do_pop) begin
         case (pop_entry.op)
            OP_BYTE: begin
               if (count_ff < CNT_W'(STORE_DEPTH)) begin
                  store_write = 1'b1;
                  count_in    = count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
            OP_CLEAR: begin
               count_in    = '0;
               overflow_in = 1'b0;
            end
            OP_CLOSE, OP_UNKNOWN, OP_REBOOT: begin
               rsp_valid_in   = 1'b1;
               frame_id_in    = '0;
               frame_size_in  = '0;
               frame_data_in  = '0;
               reboot_flag_in = '0;
               bad_command_in = '0;
               if (pop_entry.op == OP_UNKNOWN) begin
                  kind_in        = KIND_UNKNOWN;
                  bad_command_in = pop_entry.value;
               end else if (pop_entry.op == OP_REBOOT) begin
                  kind_in        = KIND_REBOOT;
                  reboot_flag_in = pop_entry.value;
                  count_in       = '0;
                  overflow_in    = 1'b0;
               end else if (close_error) begin
                  kind_in     = KIND_SIZE_ERR;
                  count_in    = '0;
                  overflow_in = 1'b0;
               end else begin
                  kind_in       = KIND_FRAME;
                  frame_id_in   = {store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
                  frame_size_in = announced[3:0];
                  frame_data_in = data_bytes;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      frame_id_ff    <= frame_id_in;
      frame_size_ff  <= frame_size_in;
      frame_data_ff  <= frame_data_in;
      reboot_flag_ff <= reboot_flag_in;
      bad_command_ff <= bad_command_in;
      if (store_write) begin
         store_ff[count_ff[IDX_W-1:0]] <= pop_entry.value;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_frame_id    = frame_id_ff;
   assign rsp_frame_size  = frame_size_ff;
   assign rsp_frame_data  = frame_data_ff;
   assign rsp_reboot_flag = reboot_flag_ff;
   assign rsp_bad_command = bad_command_ff;

endmodule

// ===== rtl/hacd_checker.sv =====
// Port-level checker for the hex-ASCII CAN frame deframer, with its bind.
// Depends on hacd_pkg and hex_ascii_can_frame_deframer.
module hacd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_in,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_frame_id,
   input logic [3:0]  rsp_frame_size,
   input logic [63:0] rsp_frame_data,
   input logic [7:0]  rsp_reboot_flag,
   input logic [7:0]  rsp_bad_command
);
   import hacd_pkg::*;

   logic unused_inputs;
   assign unused_inputs = req_valid ^ req_ready ^ (^req_char_in);

   a_frame_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FRAME |-> rsp_frame_size <= 4'(MAX_DATA_BYTES))
      else $error("frame size exceeds maximum");

   a_nonframe_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_FRAME
      |-> rsp_frame_id == '0 && rsp_frame_size == '0 && rsp_frame_data == '0)
      else $error("frame fields set on non-frame result");

   a_unknown_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_UNKNOWN
      |-> rsp_bad_command >= CHAR_UPPER_A && rsp_bad_command <= CHAR_UPPER_Z
          && rsp_bad_command != CHAR_UPPER_B && rsp_bad_command != CHAR_UPPER_C
          && rsp_bad_command != CHAR_UPPER_F && rsp_bad_command != CHAR_UPPER_Y)
      else $error("unknown command is not an unhandled letter");

   a_side_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_REBOOT || rsp_reboot_flag == '0)
                    && (rsp_kind == KIND_UNKNOWN || rsp_bad_command == '0))
      else $error("flag or command field set for wrong kind");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
                                   && $stable(rsp_frame_data))
      else $error("stalled result changed");

endmodule

bind hex_ascii_can_frame_deframer hacd_checker u_checker (.*);

// ===== sim/tb_hex_ascii_can_frame_deframer.sv =====
// Self-checking testbench for the hex-ASCII CAN frame deframer: drives characters, tracks the
// expected frame, error and reboot reports in a scoreboard class and checks every result
// transfer. Depends on hacd_pkg and hex_ascii_can_frame_deframer.
import hacd_pkg::*;

typedef struct packed {
   kind_type    kind;
   logic [31:0] frame_id;
   logic [3:0]  frame_size;
   logic [63:0] frame_data;
   logic [7:0]  reboot_flag;
   logic [7:0]  bad_command;
} deframe_report_type;

class deframe_tracker;
   logic [7:0]         store [STORE_DEPTH];
   int unsigned        count;
   bit                 overflow;
   bit                 nibble_pending;
   bit                 flag_next;
   logic [7:0]         first_char;
   deframe_report_type awaited [$];
   int unsigned        errors;

   function new();
      count          = 0;
      overflow       = 1'b0;
      nibble_pending = 1'b0;
      flag_next      = 1'b0;
      first_char     = 8'h00;
      errors         = 0;
      foreach (store[i]) store[i] = 8'h00;
   endfunction

   function logic [7:0] nibble_of(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return c - CHAR_ZERO;
      end
      return c - CHAR_LOWER_A + HEX_TEN;
   endfunction

   function deframe_report_type close_frame();
      deframe_report_type r;
      int unsigned        size;
      r = '0;
      if (overflow || count < HEADER_BYTES || 32'(store[4]) != count - HEADER_BYTES ||
          32'(store[4]) > MAX_DATA_BYTES) begin
         count    = 0;
         overflow = 1'b0;
         r.kind   = KIND_SIZE_ERR;
         return r;
      end
      size         = 32'(store[4]);
      r.kind       = KIND_FRAME;
      r.frame_id   = {store[3], store[2], store[1], store[0]};
      r.frame_size = 4'(size);
      for (int i = 0; i < size; i++) r.frame_data[8*i +: 8] = store[HEADER_BYTES + i];
      return r;
   endfunction

   function void note_char(logic [7:0] c);
      deframe_report_type r;
      logic [7:0]         hi;
      logic [7:0]         b;
      r = '0;
      if (flag_next) begin
         flag_next     = 1'b0;
         count         = 0;
         overflow      = 1'b0;
         r.kind        = KIND_REBOOT;
         r.reboot_flag = c;
         awaited.push_back(r);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         if (c == CHAR_UPPER_B || c == CHAR_UPPER_C) begin
            count    = 0;
            overflow = 1'b0;
         end else if (c == CHAR_UPPER_Y) begin
            flag_next = 1'b1;
         end else if (c == CHAR_UPPER_F) begin
            awaited.push_back(close_frame());
         end else begin
            r.kind        = KIND_UNKNOWN;
            r.bad_command = c;
            awaited.push_back(r);
         end
      end else if (!nibble_pending) begin
         first_char     = c;
         nibble_pending = 1'b1;
      end else begin
         nibble_pending = 1'b0;
         hi = nibble_of(first_char);
         b  = {hi[3:0], 4'h0} | nibble_of(c);
         if (count < STORE_DEPTH) begin
            store[count] = b;
            count++;
         end else begin
            overflow = 1'b1;
         end
      end
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_report(kind_type kind, logic [31:0] id, logic [3:0] size, logic [63:0] data,
                     logic [7:0] flag, logic [7:0] bad);
      deframe_report_type e;
      if (awaited.size() == 0) begin
         report($sformatf("result of kind %0d with nothing awaited", kind));
         return;
      end
      e = awaited.pop_front();
      if (kind !== e.kind)
         report($sformatf("kind %0d, want %0d", kind, e.kind));
      if (id !== e.frame_id)
         report($sformatf("frame_id %h, want %h", id, e.frame_id));
      if (size !== e.frame_size)
         report($sformatf("frame_size %0d, want %0d", size, e.frame_size));
      if (data !== e.frame_data)
         report($sformatf("frame_data %h, want %h", data, e.frame_data));
      if (flag !== e.reboot_flag)
         report($sformatf("reboot_flag %h, want %h", flag, e.reboot_flag));
      if (bad !== e.bad_command)
         report($sformatf("bad_command %h, want %h", bad, e.bad_command));
   endtask
endclass

module tb_hex_ascii_can_frame_deframer;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 200;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_ready   = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_frame_id;
   logic [3:0]  rsp_frame_size;
   logic [63:0] rsp_frame_data;
   logic [7:0]  rsp_reboot_flag;
   logic [7:0]  rsp_bad_command;

   deframe_tracker tracker;
   logic [7:0]     burst [$];
   int unsigned    send_idle_pct  = 8;
   int unsigned    recv_stall_pct = 72;
   int unsigned    cycles         = 0;
   int unsigned    sent           = 0;

   hex_ascii_can_frame_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_frame_id(rsp_frame_id),
      .rsp_frame_size(rsp_frame_size),
      .rsp_frame_data(rsp_frame_data),
      .rsp_reboot_flag(rsp_reboot_flag),
      .rsp_bad_command(rsp_bad_command)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_report(rsp_kind, rsp_frame_id, rsp_frame_size, rsp_frame_data,
                              rsp_reboot_flag, rsp_bad_command);
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task send_char(logic [7:0] c);
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_char(c);
      sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task send_burst();
      while (burst.size() != 0) send_char(burst.pop_front());
   endtask

   function logic [7:0] hex_char(logic [3:0] n);
      logic [7:0] c;
      if ($urandom_range(9) == 0) begin
         c = 8'($urandom_range(255));
         while (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = 8'($urandom_range(255));
         return c;
      end
      if (n < 10) return CHAR_ZERO + n;
      return CHAR_LOWER_A + n - HEX_TEN;
   endfunction

   function void add_byte(logic [7:0] b);
      burst.push_back(hex_char(b[7:4]));
      burst.push_back(hex_char(b[3:0]));
   endfunction

   function void build_burst();
      int unsigned choice;
      int unsigned n;
      burst.delete();
      if (tracker.flag_next) burst.push_back(8'($urandom_range(255)));
      if (tracker.nibble_pending) burst.push_back(hex_char(4'($urandom_range(15))));
      choice = $urandom_range(99);
      if (choice < 55) begin
         if ($urandom_range(9) < 8) burst.push_back($urandom_range(1) ? CHAR_UPPER_B : CHAR_UPPER_C);
         repeat (4) add_byte(8'($urandom_range(255)));
         n = ($urandom_range(3) == 0) ? MAX_DATA_BYTES : $urandom_range(MAX_DATA_BYTES);
         add_byte(8'(($urandom_range(9) == 0) ? $urandom_range(255) : n));
         repeat (n) add_byte(8'($urandom_range(255)));
         burst.push_back(CHAR_UPPER_F);
         if ($urandom_range(4) == 0) burst.push_back(CHAR_UPPER_F);
      end else if (choice < 65) begin
         burst.push_back(CHAR_UPPER_C);
         repeat (4) add_byte(8'($urandom_range(255)));
         add_byte(8'(MAX_DATA_BYTES));
         repeat (MAX_DATA_BYTES + $urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
         burst.push_back(CHAR_UPPER_F);
      end else if (choice < 75) begin
         burst.push_back(CHAR_UPPER_Y);
         burst.push_back(8'($urandom_range(255)));
      end else if (choice < 85) begin
         burst.push_back(8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z)));
      end else begin
         repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(255)));
      end
   endfunction

   task run_phase(int unsigned idle_pct, int unsigned stall_pct);
      int unsigned target;
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
         build_burst();
         send_burst();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      burst = {CHAR_UPPER_A, CHAR_UPPER_Z,
               "0", "1", "2", "3", "4", "5", "6", "7", "0", "0", CHAR_UPPER_F, CHAR_UPPER_F,
               CHAR_UPPER_Y, CHAR_UPPER_F, CHAR_UPPER_F,
               "9", CHAR_UPPER_B, "a", CHAR_UPPER_C,
               8'hFF, 8'h00, 8'h40, 8'h5B, CHAR_UPPER_F};
      send_burst();

      run_phase(8, 72);
      run_phase(72, 8);
      run_phase(0, 0);

      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
